// ===== rtl/assert_macros.svh =====
// Assertion macros for the engine's top-level RTL file.
// No dependencies; the bodies drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Invariant that holds at every clock edge out of reset.
`define BFIE_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle that forces a result in the next.
`define BFIE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define BFIE_ASSERT(name, clk, rst_n, prop, msg)
`define BFIE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/bfie_pkg.sv =====
// Package of the instruction engine: sizes, opcodes, status codes, microcode types.
// No dependencies; used by bfie_seq, the engine top and the scoreboard package.
`default_nettype none

package bfie_pkg;

  localparam int unsigned PROGRAM_DEPTH = 512;
  localparam int unsigned TAPE_DEPTH    = 512;
  localparam int unsigned STACK_DEPTH   = 256;

  localparam int unsigned PA_W = $clog2(PROGRAM_DEPTH);      // program memory address
  localparam int unsigned PC_W = $clog2(PROGRAM_DEPTH + 1);  // counter / length
  localparam int unsigned TP_W = $clog2(TAPE_DEPTH);         // tape pointer
  localparam int unsigned SA_W = $clog2(STACK_DEPTH);        // stack address
  localparam int unsigned SD_W = $clog2(STACK_DEPTH + 1);    // stack depth
  localparam int unsigned STEP_W = 5;

  localparam logic [7:0] OP_RIGHT = 8'h3E;
  localparam logic [7:0] OP_LEFT  = 8'h3C;
  localparam logic [7:0] OP_INC   = 8'h2B;
  localparam logic [7:0] OP_DEC   = 8'h2D;
  localparam logic [7:0] OP_OUT   = 8'h2E;
  localparam logic [7:0] OP_IN    = 8'h2C;
  localparam logic [7:0] OP_OPEN  = 8'h5B;
  localparam logic [7:0] OP_CLOSE = 8'h5D;

  typedef enum logic [1:0] {
    ACT_LOAD,
    ACT_STEP,
    ACT_RESTART,
    ACT_NONE
  } act_e;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_END,
    ST_OVER,
    ST_UNDER,
    ST_FULL
  } status_e;

  // Datapath operation of one microcode step.
  typedef enum logic [4:0] {
    U_NOP,
    U_CLEAR,
    U_ACCEPT,
    U_LOAD,
    U_EXEC,
    U_RIGHT,
    U_LEFT,
    U_INC,
    U_DEC,
    U_OUT,
    U_IN,
    U_ADV,
    U_OPEN,
    U_SCAN_RD,
    U_SCAN_CHK,
    U_CLOSE,
    U_RET,
    U_RESTART,
    U_EMIT
  } uop_e;

  typedef enum logic [2:0] {
    J_GOTO,      // unconditional
    J_IF,        // condition -> target, else next step
    J_HOLD,      // stay while condition, then target
    J_DISP_ACT,  // map on the action of the input beat
    J_DISP_OP    // map on the fetched opcode
  } jump_e;

  typedef enum logic [2:0] {
    C_NONE,
    C_CLR_MORE,
    C_STOP,
    C_CELL_NZ,
    C_SCAN_END,
    C_NO_MATCH,
    C_SD_ZERO,
    C_OUT_BUSY
  } cond_e;

  typedef enum logic [STEP_W-1:0] {
    S_RCLR,
    S_IDLE,
    S_LOAD,
    S_EXEC,
    S_FETCH,
    S_RIGHT,
    S_LEFT,
    S_INC,
    S_DEC,
    S_OUT,
    S_IN,
    S_ADV,
    S_OPEN,
    S_SCAN,
    S_SCAN2,
    S_FIN,
    S_CLOSE,
    S_RET,
    S_RST
  } step_e;

  typedef struct packed {
    uop_e  uop;
    jump_e jump;
    cond_e cond;
    step_e target;
  } cw_t;

  // Status flags from the datapath that the sequencer branches on.
  typedef struct packed {
    logic clr_more;
    logic stop;
    logic cell_nz;
    logic scan_end;
    logic no_match;
    logic sd_zero;
    logic out_busy;
  } cond_t;

endpackage

`default_nettype wire

// ===== rtl/bfie_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module bfie_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bfie_seq.sv =====
// Microcode sequencer: step counter, control ROM and branch/dispatch logic.
// Depends on bfie_pkg.
`default_nettype none

module bfie_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      action_i,
  input  logic [7:0]      opcode_i,
  input  bfie_pkg::cond_t cond_i,
  output bfie_pkg::uop_e  uop_o
);

  import bfie_pkg::*;

  step_e step_q, step_d;
  cw_t   cw;
  logic  cond_hit;

  // Control store.
  function automatic cw_t rom(input step_e s);
    cw_t w;
    w = '{uop: U_NOP, jump: J_GOTO, cond: C_NONE, target: S_IDLE};
    unique case (s)
      S_RCLR:  w = '{uop: U_CLEAR,    jump: J_HOLD,     cond: C_CLR_MORE, target: S_IDLE};
      S_IDLE:  w = '{uop: U_ACCEPT,   jump: J_DISP_ACT, cond: C_NONE,     target: S_IDLE};
      S_LOAD:  w = '{uop: U_LOAD,     jump: J_GOTO,     cond: C_NONE,     target: S_FIN};
      S_EXEC:  w = '{uop: U_EXEC,     jump: J_IF,       cond: C_STOP,     target: S_FIN};
      S_FETCH: w = '{uop: U_NOP,      jump: J_DISP_OP,  cond: C_NONE,     target: S_ADV};
      S_RIGHT: w = '{uop: U_RIGHT,    jump: J_GOTO,     cond: C_NONE,     target: S_FIN};
      S_LEFT:  w = '{uop: U_LEFT,     jump: J_GOTO,     cond: C_NONE,     target: S_FIN};
      S_INC:   w = '{uop: U_INC,      jump: J_GOTO,     cond: C_NONE,     target: S_FIN};
      S_DEC:   w = '{uop: U_DEC,      jump: J_GOTO,     cond: C_NONE,     target: S_FIN};
      S_OUT:   w = '{uop: U_OUT,      jump: J_GOTO,     cond: C_NONE,     target: S_FIN};
      S_IN:    w = '{uop: U_IN,       jump: J_GOTO,     cond: C_NONE,     target: S_FIN};
      S_ADV:   w = '{uop: U_ADV,      jump: J_GOTO,     cond: C_NONE,     target: S_FIN};
      S_OPEN:  w = '{uop: U_OPEN,     jump: J_IF,       cond: C_CELL_NZ,  target: S_FIN};
      S_SCAN:  w = '{uop: U_SCAN_RD,  jump: J_IF,       cond: C_SCAN_END, target: S_FIN};
      // falls through into S_FIN on the matching bracket
      S_SCAN2: w = '{uop: U_SCAN_CHK, jump: J_IF,       cond: C_NO_MATCH, target: S_SCAN};
      S_FIN:   w = '{uop: U_EMIT,     jump: J_HOLD,     cond: C_OUT_BUSY, target: S_IDLE};
      S_CLOSE: w = '{uop: U_CLOSE,    jump: J_IF,       cond: C_SD_ZERO,  target: S_FIN};
      S_RET:   w = '{uop: U_RET,      jump: J_GOTO,     cond: C_NONE,     target: S_FIN};
      S_RST:   w = '{uop: U_RESTART,  jump: J_HOLD,     cond: C_CLR_MORE, target: S_FIN};
      default: w = '{uop: U_NOP,      jump: J_GOTO,     cond: C_NONE,     target: S_IDLE};
    endcase
    return w;
  endfunction

  assign cw = rom(step_q);

  always_comb begin
    unique case (cw.cond)
      C_CLR_MORE: cond_hit = cond_i.clr_more;
      C_STOP:     cond_hit = cond_i.stop;
      C_CELL_NZ:  cond_hit = cond_i.cell_nz;
      C_SCAN_END: cond_hit = cond_i.scan_end;
      C_NO_MATCH: cond_hit = cond_i.no_match;
      C_SD_ZERO:  cond_hit = cond_i.sd_zero;
      C_OUT_BUSY: cond_hit = cond_i.out_busy;
      default:    cond_hit = 1'b0;
    endcase
  end

  // Next step.
  always_comb begin
    step_d = step_q;
    unique case (cw.jump)
      J_GOTO: step_d = cw.target;
      J_IF:   step_d = cond_hit ? cw.target : step_e'(step_q + STEP_W'(1));
      J_HOLD: step_d = cond_hit ? step_q : cw.target;
      J_DISP_ACT: begin
        if (in_valid_i) begin
          case (action_i)
            ACT_LOAD:    step_d = S_LOAD;
            ACT_STEP:    step_d = S_EXEC;
            ACT_RESTART: step_d = S_RST;
            default:     step_d = S_FIN;
          endcase
        end
      end
      J_DISP_OP: begin
        case (opcode_i)
          OP_RIGHT: step_d = S_RIGHT;
          OP_LEFT:  step_d = S_LEFT;
          OP_INC:   step_d = S_INC;
          OP_DEC:   step_d = S_DEC;
          OP_OUT:   step_d = S_OUT;
          OP_IN:    step_d = S_IN;
          OP_OPEN:  step_d = S_OPEN;
          OP_CLOSE: step_d = S_CLOSE;
          default:  step_d = cw.target;
        endcase
      end
      default: step_d = S_IDLE;
    endcase
  end

  always_comb begin
    uop_o = cw.uop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_RCLR;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/brainfuck_instruction_engine.sv =====
// Instruction engine for the eight-command tape language. Each input beat carries
// an action: load appends program_byte to program memory (status full once it
// is full), step runs one instruction (a '[' on a zero cell scans forward to its
// matching ']' and ends the program when none follows; a ']' with an open '['
// returns to it), restart clears tape, stack and counters (one tape cell per
// cycle), and the unused action returns status 0. The final step of a beat also
// waits while a previous result is still held in the output register.
// Every beat yields exactly one result beat.
// After reset the engine clears the whole tape with in_ready_o low. Results sit
// in an output register, so a new input beat is taken while the previous result
// still waits for res_ready_i.
// Depends on bfie_pkg, bfie_seq, bfie_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module brainfuck_instruction_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [7:0] program_byte_i,
  input  logic [7:0] input_byte_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       input_used_o,
  output logic [2:0] status_o
);

  import bfie_pkg::*;

  uop_e  uop;
  cond_t cond;

  // Architectural state.
  logic [PC_W-1:0] prog_len_q, prog_len_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic [TP_W-1:0] tp_q, tp_d;
  logic [SD_W-1:0] sd_q, sd_d;
  logic            halted_q, halted_d;
  status_e         hcode_q, hcode_d;

  // Sequencer scratch.
  logic [TP_W-1:0] clr_q, clr_d;
  logic [PC_W-1:0] scan_q, scan_d;
  logic [PC_W-1:0] level_q, level_d;
  logic [7:0]      pbyte_q, pbyte_d;
  logic [7:0]      ibyte_q, ibyte_d;

  // Result being built for the current beat.
  logic    r_outv_q, r_outv_d;
  logic [7:0] r_byte_q, r_byte_d;
  logic    r_used_q, r_used_d;
  status_e r_status_q, r_status_d;

  // Output register.
  logic    res_valid_q, res_valid_d;
  logic    out_valid_q;
  logic [7:0] out_byte_q;
  logic    input_used_q;
  status_e status_q;
  logic    emit;

  // RAM ports.
  logic            pm_we, pm_re;
  logic [PA_W-1:0] pm_addr;
  logic [7:0]      pm_rdata;
  logic            tm_we, tm_re;
  logic [TP_W-1:0] tm_addr;
  logic [7:0]      tm_wdata, tm_rdata;
  logic            sk_we, sk_re;
  logic [SA_W-1:0] sk_addr;
  logic [PC_W-1:0] sk_rdata;
  logic [SD_W-1:0] sd_m1;

  bfie_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .opcode_i   (pm_rdata),
    .cond_i     (cond),
    .uop_o      (uop)
  );

  bfie_ram #(.DEPTH(PROGRAM_DEPTH), .WIDTH(8)) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (pm_we),
    .re_i    (pm_re),
    .addr_i  (pm_addr),
    .wdata_i (pbyte_q),
    .rdata_o (pm_rdata)
  );

  bfie_ram #(.DEPTH(TAPE_DEPTH), .WIDTH(8)) u_tape_ram (
    .clk_i   (clk_i),
    .we_i    (tm_we),
    .re_i    (tm_re),
    .addr_i  (tm_addr),
    .wdata_i (tm_wdata),
    .rdata_o (tm_rdata)
  );

  bfie_ram #(.DEPTH(STACK_DEPTH), .WIDTH(PC_W)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (sk_we),
    .re_i    (sk_re),
    .addr_i  (sk_addr),
    .wdata_i (pc_q),
    .rdata_o (sk_rdata)
  );

  assign sd_m1 = sd_q - SD_W'(1);

  // Branch conditions for the sequencer.
  always_comb begin
    cond.clr_more = (clr_q != TP_W'(TAPE_DEPTH - 1));
    cond.stop     = halted_q || (pc_q >= prog_len_q);
    cond.cell_nz  = (tm_rdata != 8'd0);
    cond.scan_end = (scan_q >= prog_len_q);
    cond.no_match = !((pm_rdata == OP_CLOSE) && (level_q == PC_W'(1)));
    cond.sd_zero  = (sd_q == '0);
    cond.out_busy = res_valid_q && !res_ready_i;
  end

  assign in_ready_o = (uop == U_ACCEPT);
  assign emit       = (uop == U_EMIT) && !cond.out_busy;

  // RAM addressing follows the current operation.
  always_comb begin
    unique case (uop)
      U_LOAD:    pm_addr = prog_len_q[PA_W-1:0];
      U_SCAN_RD: pm_addr = scan_q[PA_W-1:0];
      default:   pm_addr = pc_q[PA_W-1:0];
    endcase
    tm_addr = ((uop == U_CLEAR) || (uop == U_RESTART)) ? clr_q : tp_q;
    sk_addr = (uop == U_CLOSE) ? sd_m1[SA_W-1:0] : sd_q[SA_W-1:0];
  end

  // Datapath: one operation per microcode step.
  always_comb begin
    prog_len_d = prog_len_q;
    pc_d       = pc_q;
    tp_d       = tp_q;
    sd_d       = sd_q;
    halted_d   = halted_q;
    hcode_d    = hcode_q;
    clr_d      = clr_q;
    scan_d     = scan_q;
    level_d    = level_q;
    pbyte_d    = pbyte_q;
    ibyte_d    = ibyte_q;
    r_outv_d   = r_outv_q;
    r_byte_d   = r_byte_q;
    r_used_d   = r_used_q;
    r_status_d = r_status_q;
    pm_we      = 1'b0;
    pm_re      = 1'b0;
    tm_we      = 1'b0;
    tm_re      = 1'b0;
    tm_wdata   = 8'd0;
    sk_we      = 1'b0;
    sk_re      = 1'b0;

    case (uop)
      U_CLEAR: begin
        tm_we = 1'b1;
        clr_d = cond.clr_more ? clr_q + TP_W'(1) : '0;
      end
      U_RESTART: begin
        tm_we    = 1'b1;
        clr_d    = cond.clr_more ? clr_q + TP_W'(1) : '0;
        pc_d     = '0;
        tp_d     = '0;
        sd_d     = '0;
        halted_d = 1'b0;
        hcode_d  = ST_RUN;
      end
      U_ACCEPT: begin
        if (in_valid_i) begin
          pbyte_d    = program_byte_i;
          ibyte_d    = input_byte_i;
          r_outv_d   = 1'b0;
          r_byte_d   = 8'd0;
          r_used_d   = 1'b0;
          r_status_d = ST_RUN;
        end
      end
      U_LOAD: begin
        if (prog_len_q == PC_W'(PROGRAM_DEPTH)) begin
          r_status_d = ST_FULL;
        end else begin
          pm_we      = 1'b1;
          prog_len_d = prog_len_q + PC_W'(1);
        end
      end
      U_EXEC: begin
        if (halted_q) begin
          r_status_d = hcode_q;
        end else if (pc_q >= prog_len_q) begin
          halted_d   = 1'b1;
          hcode_d    = ST_END;
          r_status_d = ST_END;
        end else begin
          pm_re = 1'b1;
          tm_re = 1'b1;
        end
      end
      U_RIGHT: begin
        tp_d = (tp_q == TP_W'(TAPE_DEPTH - 1)) ? '0 : tp_q + TP_W'(1);
        pc_d = pc_q + PC_W'(1);
      end
      U_LEFT: begin
        tp_d = (tp_q == '0) ? TP_W'(TAPE_DEPTH - 1) : tp_q - TP_W'(1);
        pc_d = pc_q + PC_W'(1);
      end
      U_INC: begin
        tm_we    = 1'b1;
        tm_wdata = tm_rdata + 8'd1;
        pc_d     = pc_q + PC_W'(1);
      end
      U_DEC: begin
        tm_we    = 1'b1;
        tm_wdata = tm_rdata - 8'd1;
        pc_d     = pc_q + PC_W'(1);
      end
      U_OUT: begin
        r_outv_d = 1'b1;
        r_byte_d = tm_rdata;
        pc_d     = pc_q + PC_W'(1);
      end
      U_IN: begin
        tm_we    = 1'b1;
        tm_wdata = ibyte_q;
        r_used_d = 1'b1;
        pc_d     = pc_q + PC_W'(1);
      end
      U_ADV: begin
        pc_d = pc_q + PC_W'(1);
      end
      U_OPEN: begin
        if (cond.cell_nz) begin
          if (sd_q == SD_W'(STACK_DEPTH)) begin
            halted_d   = 1'b1;
            hcode_d    = ST_OVER;
            r_status_d = ST_OVER;
          end else begin
            sk_we = 1'b1;
            sd_d  = sd_q + SD_W'(1);
            pc_d  = pc_q + PC_W'(1);
          end
        end else begin
          scan_d  = pc_q + PC_W'(1);
          level_d = PC_W'(1);
        end
      end
      U_SCAN_RD: begin
        if (cond.scan_end) begin
          pc_d       = prog_len_q;
          halted_d   = 1'b1;
          hcode_d    = ST_END;
          r_status_d = ST_END;
        end else begin
          pm_re = 1'b1;
        end
      end
      U_SCAN_CHK: begin
        if (pm_rdata == OP_OPEN) begin
          level_d = level_q + PC_W'(1);
        end else if (pm_rdata == OP_CLOSE) begin
          if (level_q == PC_W'(1)) begin
            pc_d = scan_q + PC_W'(1);
          end else begin
            level_d = level_q - PC_W'(1);
          end
        end
        scan_d = scan_q + PC_W'(1);
      end
      U_CLOSE: begin
        if (cond.sd_zero) begin
          halted_d   = 1'b1;
          hcode_d    = ST_UNDER;
          r_status_d = ST_UNDER;
        end else begin
          sd_d  = sd_m1;
          sk_re = 1'b1;
        end
      end
      U_RET: begin
        pc_d = sk_rdata;
      end
      default: begin
      end
    endcase
  end

  // Output register: loads on emit, drains on the result handshake.
  always_comb begin
    res_valid_d = res_valid_q;
    if (emit) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_len_q  <= '0;
      pc_q        <= '0;
      tp_q        <= '0;
      sd_q        <= '0;
      halted_q    <= 1'b0;
      hcode_q     <= ST_RUN;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      prog_len_q  <= prog_len_d;
      pc_q        <= pc_d;
      tp_q        <= tp_d;
      sd_q        <= sd_d;
      halted_q    <= halted_d;
      hcode_q     <= hcode_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q     <= scan_d;
    level_q    <= level_d;
    pbyte_q    <= pbyte_d;
    ibyte_q    <= ibyte_d;
    r_outv_q   <= r_outv_d;
    r_byte_q   <= r_byte_d;
    r_used_q   <= r_used_d;
    r_status_q <= r_status_d;
    if (emit) begin
      out_valid_q  <= r_outv_q;
      out_byte_q   <= r_byte_q;
      input_used_q <= r_used_q;
      status_q     <= r_status_q;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign input_used_o = input_used_q;
  assign status_o     = status_q;

  `BFIE_ASSERT(a_pc_le_len, clk_i, rst_ni, pc_q <= prog_len_q, "pc past program end")
  `BFIE_ASSERT(a_sd_range, clk_i, rst_ni, sd_q <= SD_W'(STACK_DEPTH), "stack depth out of range")
  `BFIE_ASSERT(a_halt_code, clk_i, rst_ni, !halted_q || (hcode_q != ST_RUN), "halted with run code")
  `BFIE_ASSERT_NEXT(a_emit_lands, clk_i, rst_ni, emit, res_valid_q, "emitted beat not presented")

endmodule

`default_nettype wire

// ===== tb/bfie_scoreboard_pkg.sv =====
// Scoreboard for the instruction engine testbench: a cycle-free model of the
// machine plus the queue of result beats it predicts. Depends on bfie_pkg.
`timescale 1ns / 1ps

package bfie_scoreboard_pkg;
  import bfie_pkg::*;

  typedef struct packed {
    logic       emitted;
    logic [7:0] emit_byte;
    logic       took_input;
    status_e    status;
  } bf_result_t;

  class bfie_scoreboard;
    bit [7:0]    code_mem [PROGRAM_DEPTH];
    int unsigned code_len;
    int unsigned pc;
    bit [7:0]    cells [TAPE_DEPTH];
    int unsigned head;
    int unsigned loop_stack [STACK_DEPTH];
    int unsigned depth;
    bit          stopped;
    status_e     stop_code;

    bf_result_t  pending_results [$];
    int unsigned mismatches;
    int unsigned result_idx;

    function new();
      code_len    = 0;
      mismatches  = 0;
      result_idx  = 0;
      clear_run();
    endfunction

    // Restart: program stays; tape, pc, head, depth and halt state go back to zero.
    function void clear_run();
      foreach (cells[i]) cells[i] = 8'h00;
      pc        = 0;
      head      = 0;
      depth     = 0;
      stopped   = 1'b0;
      stop_code = ST_RUN;
    endfunction

    function status_e halt_with(status_e why);
      stopped   = 1'b1;
      stop_code = why;
      return why;
    endfunction

    // One instruction at pc; returns the status of the step.
    function status_e execute_one(bit [7:0] in_b, output bit emitted,
                                  output bit [7:0] emit_byte, output bit took);
      bit [7:0]    op;
      int unsigned lvl;
      int unsigned scan;
      emitted   = 1'b0;
      emit_byte = 8'h00;
      took      = 1'b0;
      if (stopped) return stop_code;
      if (pc >= code_len) return halt_with(ST_END);
      op = code_mem[pc];
      case (op)
        OP_RIGHT: head = (head + 1) % TAPE_DEPTH;
        OP_LEFT:  head = (head + TAPE_DEPTH - 1) % TAPE_DEPTH;
        OP_INC:   cells[head] = cells[head] + 8'd1;
        OP_DEC:   cells[head] = cells[head] - 8'd1;
        OP_OUT: begin
          emitted   = 1'b1;
          emit_byte = cells[head];
        end
        OP_IN: begin
          cells[head] = in_b;
          took        = 1'b1;
        end
        OP_OPEN: begin
          if (cells[head] == 8'h00) begin
            // forward skip to the bracket that closes this one
            lvl  = 1;
            scan = pc + 1;
            while (scan < code_len) begin
              if (code_mem[scan] == OP_OPEN) begin
                lvl++;
              end else if (code_mem[scan] == OP_CLOSE) begin
                lvl--;
                if (lvl == 0) break;
              end
              scan++;
            end
            if (lvl != 0) begin
              pc = code_len;
              return halt_with(ST_END);
            end
            pc = scan + 1;
            return ST_RUN;
          end
          if (depth >= STACK_DEPTH) return halt_with(ST_OVER);
          loop_stack[depth] = pc;
          depth++;
        end
        OP_CLOSE: begin
          if (depth == 0) return halt_with(ST_UNDER);
          depth--;
          pc = loop_stack[depth];
          return ST_RUN;
        end
        default: ;
      endcase
      pc++;
      return ST_RUN;
    endfunction

    // Accepted input beat: advance the model and queue the result it causes.
    function void take_beat(act_e act, bit [7:0] pb, bit [7:0] ib);
      bf_result_t r;
      bit         em;
      bit [7:0]   eb;
      bit         tk;
      r        = '0;
      r.status = ST_RUN;
      case (act)
        ACT_LOAD: begin
          if (code_len >= PROGRAM_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            code_mem[code_len] = pb;
            code_len++;
          end
        end
        ACT_STEP: begin
          r.status     = execute_one(ib, em, eb, tk);
          r.emitted    = em;
          r.emit_byte  = eb;
          r.took_input = tk;
        end
        ACT_RESTART: clear_run();
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_result(logic ov, logic [7:0] ob, logic iu, logic [2:0] st);
      bf_result_t want;
      result_idx++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with none outstanding: out_valid=%0b out_byte=%02h",
                   result_idx, ov, ob);
        return;
      end
      want = pending_results.pop_front();
      if (ov !== want.emitted || ob !== want.emit_byte ||
          iu !== want.took_input || st !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result %0d mismatch: expected out_valid=%0b out_byte=%02h ",
                    "input_used=%0b status=%0d, got %0b %02h %0b %0d"},
                   result_idx, want.emitted, want.emit_byte, want.took_input,
                   want.status, ov, ob, iu, st);
      end
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

endpackage

// ===== tb/tb_brainfuck_instruction_engine.sv =====
// Testbench top for brainfuck_instruction_engine: random beats on both
// valid/ready channels, every result beat checked against bfie_scoreboard.
// Depends on bfie_pkg, bfie_scoreboard_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb_brainfuck_instruction_engine;
  import bfie_pkg::*;
  import bfie_scoreboard_pkg::*;

  // Program bytes that random snippets may fill, guard included. Leaves room
  // for the closing bracket, one '+' and a chain of STACK_DEPTH + 1 opens.
  localparam int unsigned EARLY_BYTES = PROGRAM_DEPTH - STACK_DEPTH - 3;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic [1:0] action_i       = 2'b00;
  logic [7:0] program_byte_i = 8'h00;
  logic [7:0] input_byte_i   = 8'h00;
  logic       res_valid_o;
  logic       res_ready_i    = 1'b0;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       input_used_o;
  logic [2:0] status_o;

  bfie_scoreboard sb = new();
  int unsigned    beat_cnt = 0;
  bit             quiet    = 1'b0;   // no idling on either side while set

  brainfuck_instruction_engine u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .program_byte_i(program_byte_i),
    .input_byte_i  (input_byte_i),
    .res_valid_o   (res_valid_o),
    .res_ready_i   (res_ready_i),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .input_used_o  (input_used_o),
    .status_o      (status_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Drive one beat from a falling edge and hold it until accepted.
  task automatic send_beat(input act_e act, input logic [7:0] pb, input logic [7:0] ib);
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < 31) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    action_i       = act;
    program_byte_i = pb;
    input_byte_i   = ib;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_beat(act, pb, ib);
    beat_cnt++;
    quiet = (beat_cnt >= 600) && (beat_cnt < 1000);
  endtask

  task automatic load_code(input logic [7:0] code[$]);
    foreach (code[i]) send_beat(ACT_LOAD, code[i], rand_byte());
  endtask

  // Restart, then a run of steps. A clean run has no noise beats and a zero
  // input on its first step, so the guard bracket at address 1 skips.
  task automatic run_program(input int unsigned steps, input bit clean);
    int unsigned pick;
    send_beat(ACT_RESTART, rand_byte(), rand_byte());
    for (int unsigned n = 0; n < steps; n++) begin
      pick = $urandom_range(0, 99);
      if (clean)
        send_beat(ACT_STEP, rand_byte(), (n == 0) ? 8'h00 : rand_byte());
      else if (pick < 3)
        send_beat(ACT_NONE, rand_byte(), rand_byte());
      else if (pick < 5)
        send_beat(ACT_RESTART, rand_byte(), rand_byte());
      else
        send_beat(ACT_STEP, rand_byte(), (pick < 30) ? 8'h00 : rand_byte());
    end
  endtask

  // Random code with balanced brackets, at most budget bytes long.
  function automatic void build_snippet(ref logic [7:0] code[$], input int unsigned budget);
    int unsigned open_cnt;
    logic [7:0]  b;
    open_cnt = 0;
    code.delete();
    while (code.size() + open_cnt < budget) begin
      case ($urandom_range(0, 15))
        0, 1: code.push_back(OP_INC);
        2:    code.push_back(OP_DEC);
        3:    code.push_back(OP_RIGHT);
        4:    code.push_back(OP_LEFT);
        5, 6: code.push_back(OP_OUT);
        7, 8: code.push_back(OP_IN);
        9: begin
          b = rand_byte();
          if (b == OP_OPEN || b == OP_CLOSE) b = 8'h00;
          code.push_back(b);
        end
        10, 11, 12: begin
          if (code.size() + open_cnt + 2 <= budget) begin
            code.push_back(OP_OPEN);
            open_cnt++;
          end
        end
        13: begin
          // clear-cell idiom, a loop that always ends
          if (code.size() + open_cnt + 3 <= budget) begin
            code.push_back(OP_OPEN);
            code.push_back(OP_DEC);
            code.push_back(OP_CLOSE);
          end
        end
        default: begin
          if (open_cnt > 0) begin
            code.push_back(OP_CLOSE);
            open_cnt--;
          end else begin
            code.push_back(OP_INC);
          end
        end
      endcase
    end
    repeat (open_cnt) code.push_back(OP_CLOSE);
  endfunction

  initial begin
    res_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      res_ready_i = quiet || ($urandom_range(0, 99) >= 31);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_valid_o && res_ready_i)
        sb.check_result(out_valid_o, out_byte_o, input_used_o, status_o);
    end
  end

  initial begin : stimulus
    logic [7:0]  code [$];
    logic [7:0]  demo [12];
    int unsigned loaded;
    bit          overflow_run;
    // Addresses 0 and 1 are a guard: ',' then '['. A zero input skips the
    // whole program body; a nonzero one enters it with the guard stacked.
    demo = '{OP_IN, OP_OPEN, OP_LEFT, OP_INC, OP_OUT, OP_RIGHT, OP_IN,
             8'h00, 8'hFF, OP_OPEN, OP_DEC, OP_CLOSE};
    wait (rst_ni === 1'b1);

    // step on an empty program ends it, a second step sees the halt
    send_beat(ACT_STEP, 8'h00, 8'hFF);
    send_beat(ACT_STEP, 8'hFF, 8'h00);
    send_beat(ACT_NONE, 8'hFF, 8'hFF);
    send_beat(ACT_RESTART, 8'h00, 8'h00);
    foreach (demo[i]) code.push_back(demo[i]);
    load_code(code);
    loaded = code.size();
    send_beat(ACT_RESTART, 8'h00, 8'h00);
    // enter the guard, wrap the pointer left and back, emit, then skip the
    // clear loop on a zero cell and run off the end
    send_beat(ACT_STEP, 8'h00, 8'hFF);
    repeat (12) send_beat(ACT_STEP, 8'hFF, 8'h00);

    // grow the program snippet by snippet, running it from the top each time
    while (loaded + 16 <= EARLY_BYTES) begin
      build_snippet(code, $urandom_range(4, 16));
      load_code(code);
      loaded += code.size();
      run_program($urandom_range(20, 60), 1'b0);
    end

    // Closing bracket for the guard, then either an open chain deep enough
    // to overflow the stack or a stray close that underflows it.
    overflow_run = $urandom_range(0, 1);
    code.delete();
    code.push_back(OP_CLOSE);
    if (overflow_run) begin
      code.push_back(OP_INC);
      repeat (STACK_DEPTH + 1) code.push_back(OP_OPEN);
    end else begin
      code.push_back(OP_CLOSE);
    end
    while (loaded + code.size() < PROGRAM_DEPTH) code.push_back(rand_byte());
    load_code(code);
    repeat (4) send_beat(ACT_LOAD, rand_byte(), rand_byte());   // memory full
    run_program(overflow_run ? STACK_DEPTH + 14 : 12, 1'b1);
    repeat (4) run_program($urandom_range(20, 60), 1'b0);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("[brainfuck_instruction_engine] OK");
    else
      $display("[brainfuck_instruction_engine] ERROR");
    $finish;
  end

  // Far beyond the slowest legal run, even with every step a full skip.
  initial begin
    #40_000_000;
    $display("[brainfuck_instruction_engine] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bfie_pkg.sv
rtl/bfie_ram.sv
rtl/bfie_seq.sv
rtl/brainfuck_instruction_engine.sv
tb/bfie_scoreboard_pkg.sv
tb/tb_brainfuck_instruction_engine.sv
